// ----- rtl/mie_pkg.sv -----
package mie_pkg;

	localparam int unsigned XLEN = 32;
	localparam int unsigned NREG = 32;
	localparam int unsigned RIDX_W = $clog2(NREG);
	localparam int unsigned MD_STEPS = 32;
	localparam int unsigned CNT_W = $clog2(MD_STEPS);
	localparam logic [CNT_W-1:0] MD_LAST = CNT_W'(MD_STEPS - 1);

	localparam logic [XLEN-1:0] START_RST = 32'h0040_0000;
	localparam logic [XLEN-1:0] SP_RST    = 32'h7FFF_EFFC;
	localparam logic [XLEN-1:0] GP_RST    = 32'h1000_8000;
	localparam logic [XLEN-1:0] JUMP_REGION = 32'hF000_0000;

	localparam logic [RIDX_W-1:0] REG_ZERO = 5'd0;
	localparam logic [RIDX_W-1:0] REG_V0   = 5'd2;
	localparam logic [RIDX_W-1:0] REG_GP   = 5'd28;
	localparam logic [RIDX_W-1:0] REG_SP   = 5'd29;
	localparam logic [RIDX_W-1:0] REG_RA   = 5'd31;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GP    = 2'd2;

	// primary opcodes
	localparam logic [5:0] OP_RTYPE   = 6'h00;
	localparam logic [5:0] OP_ZBRANCH = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDUI   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTUI   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;

	// special function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// regimm selectors in the rt field
	localparam logic [4:0] RI_BLTZ   = 5'h00;
	localparam logic [4:0] RI_BGEZ   = 5'h01;
	localparam logic [4:0] RI_BLTZAL = 5'h10;
	localparam logic [4:0] RI_BGEZAL = 5'h11;

	typedef struct packed {
		logic start;
		logic is_div;
		logic sgn;
	} md_req_t;

	typedef struct packed {
		logic              wen;
		logic [RIDX_W-1:0] wreg;
		logic [XLEN-1:0]   wval;
		logic              taken;
		logic [XLEN-1:0]   target;
		logic              sys;
		logic              unsup;
		logic              md_go;
		logic              md_div;
		logic              md_sgn;
		logic              hi_we;
		logic              lo_we;
	} alu_res_t;

endpackage

// ----- rtl/mie_ram.sv -----
module mie_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/mie_alu.sv -----
module mie_alu (
	input  logic [31:0]      ir,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	input  logic [31:0]      pc,
	input  logic [31:0]      hi,
	input  logic [31:0]      lo,
	output mie_pkg::alu_res_t res
);
	import mie_pkg::*;

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  rt_f;
	logic [4:0]  rd_f;
	logic [4:0]  sa;
	logic [4:0]  sh;
	logic [15:0] imm;
	logic [31:0] simm;
	logic [31:0] zimm;
	logic [31:0] pc4;
	logic [31:0] pc8;
	logic [31:0] btarget;
	logic [31:0] jtarget;
	logic [31:0] shl;
	logic [31:0] shr;
	logic [31:0] sra;

	assign op   = ir[31:26];
	assign rt_f = ir[20:16];
	assign rd_f = ir[15:11];
	assign sa   = ir[10:6];
	assign fn   = ir[5:0];
	assign imm  = ir[15:0];
	assign simm = {{16{imm[15]}}, imm};
	assign zimm = {16'h0000, imm};
	assign pc4  = pc + 32'd4;
	assign pc8  = pc + 32'd8;
	assign btarget = pc4 + {simm[29:0], 2'b00};
	assign jtarget = (pc4 & JUMP_REGION) | {4'h0, ir[25:0], 2'b00};

	// variable shifts take the low five bits of rs
	assign sh  = fn[2] ? a[4:0] : sa;
	assign shl = b << sh;
	assign shr = b >> sh;
	assign sra = 32'($signed(b) >>> sh);

	always_comb begin
		res = '0;
		case (op)
			OP_RTYPE: begin
				case (fn)
					FN_SLL, FN_SLLV: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = shl;
					end
					FN_SRL, FN_SRLV: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = shr;
					end
					FN_SRA, FN_SRAV: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = sra;
					end
					FN_JR: begin
						res.taken = 1'b1; res.target = a;
					end
					FN_JALR: begin
						res.taken = 1'b1; res.target = a;
						res.wen = 1'b1; res.wreg = rd_f; res.wval = pc8;
					end
					FN_SYSCALL: res.sys = 1'b1;
					FN_MFHI: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = hi;
					end
					FN_MTHI: res.hi_we = 1'b1;
					FN_MFLO: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = lo;
					end
					FN_MTLO: res.lo_we = 1'b1;
					FN_MULT: begin
						res.md_go = 1'b1; res.md_sgn = 1'b1;
					end
					FN_MULTU: res.md_go = 1'b1;
					FN_DIV: begin
						// divide by zero leaves hi and lo alone
						res.md_go = (b != 32'd0); res.md_div = 1'b1; res.md_sgn = 1'b1;
					end
					FN_DIVU: begin
						res.md_go = (b != 32'd0); res.md_div = 1'b1;
					end
					FN_ADD, FN_ADDU: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = a + b;
					end
					FN_SUB, FN_SUBU: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = a - b;
					end
					FN_AND: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = a & b;
					end
					FN_OR: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = a | b;
					end
					FN_XOR: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = a ^ b;
					end
					FN_NOR: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = ~(a | b);
					end
					FN_SLT: begin
						res.wen = 1'b1; res.wreg = rd_f;
						res.wval = {31'd0, $signed(a) < $signed(b)};
					end
					FN_SLTU: begin
						res.wen = 1'b1; res.wreg = rd_f; res.wval = {31'd0, a < b};
					end
					default: res.unsup = 1'b1;
				endcase
			end
			OP_ZBRANCH: begin
				res.target = btarget;
				case (rt_f)
					RI_BLTZ: res.taken = a[31];
					RI_BGEZ: res.taken = !a[31];
					RI_BLTZAL: begin
						res.taken = a[31];
						res.wen = 1'b1; res.wreg = REG_RA; res.wval = pc8;
					end
					RI_BGEZAL: begin
						res.taken = !a[31];
						res.wen = 1'b1; res.wreg = REG_RA; res.wval = pc8;
					end
					default: res.unsup = 1'b1;
				endcase
			end
			OP_J: begin
				res.taken = 1'b1; res.target = jtarget;
			end
			OP_JAL: begin
				res.taken = 1'b1; res.target = jtarget;
				res.wen = 1'b1; res.wreg = REG_RA; res.wval = pc8;
			end
			OP_BEQ: begin
				res.taken = (a == b); res.target = btarget;
			end
			OP_BNE: begin
				res.taken = (a != b); res.target = btarget;
			end
			OP_BLEZ: begin
				res.taken = (a == 32'd0) || a[31]; res.target = btarget;
			end
			OP_BGTZ: begin
				res.taken = (a != 32'd0) && !a[31]; res.target = btarget;
			end
			OP_ADDI, OP_ADDUI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = a + simm;
			end
			OP_SLTI: begin
				res.wen = 1'b1; res.wreg = rt_f;
				res.wval = {31'd0, $signed(a) < $signed(simm)};
			end
			OP_SLTUI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = {31'd0, a < simm};
			end
			OP_ANDI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = a & zimm;
			end
			OP_ORI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = a | zimm;
			end
			OP_XORI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = a ^ zimm;
			end
			OP_LUI: begin
				res.wen = 1'b1; res.wreg = rt_f; res.wval = {imm, 16'h0000};
			end
			default: res.unsup = 1'b1;
		endcase
		// writes to r0 are dropped
		if (res.wreg == REG_ZERO) begin
			res.wen  = 1'b0;
			res.wval = '0;
		end
	end

endmodule

// ----- rtl/mie_muldiv.sv -----
module mie_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  mie_pkg::md_req_t req,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	output logic             done,
	output logic [31:0]      hi,
	output logic [31:0]      lo
);
	import mie_pkg::*;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_RUN  = 3'b010,
		MD_FIX  = 3'b100
	} md_state_t;

	md_state_t        state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      hi_q;
	logic [31:0]      lo_q;
	logic [31:0]      ub_q;
	logic             is_div_q;
	logic             neg_q;
	logic             rneg_q;
	logic             done_q;

	logic [31:0] ua;
	logic [31:0] ub;
	logic [32:0] rsh;
	logic [32:0] add_a;
	logic [32:0] add_b;
	logic [32:0] sum;
	logic [63:0] prod_neg;

	assign ua = (req.sgn && a[31]) ? (32'd0 - a) : a;
	assign ub = (req.sgn && b[31]) ? (32'd0 - b) : b;

	// one shared 33-bit adder: add for multiply, subtract for divide
	assign rsh   = {hi_q, lo_q[31]};
	assign add_a = is_div_q ? rsh : {1'b0, hi_q};
	assign add_b = is_div_q ? ~{1'b0, ub_q} : (lo_q[0] ? {1'b0, ub_q} : 33'd0);
	assign sum   = add_a + add_b + {32'd0, is_div_q};
	assign prod_neg = 64'd0 - {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= MD_RUN;
					end
				end
				MD_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MD_LAST) begin
						state_q <= MD_FIX;
					end
				end
				MD_FIX: begin
					done_q  <= 1'b1;
					state_q <= MD_IDLE;
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					hi_q     <= '0;
					lo_q     <= ua;
					ub_q     <= ub;
					is_div_q <= req.is_div;
					neg_q    <= req.sgn && (a[31] ^ b[31]);
					rneg_q   <= req.sgn && a[31];
				end
			end
			MD_RUN: begin
				if (is_div_q) begin
					// restoring step: borrow out means keep the shifted remainder
					if (sum[32]) begin
						hi_q <= rsh[31:0];
						lo_q <= {lo_q[30:0], 1'b0};
					end else begin
						hi_q <= sum[31:0];
						lo_q <= {lo_q[30:0], 1'b1};
					end
				end else begin
					hi_q <= sum[32:1];
					lo_q <= {sum[0], lo_q[31:1]};
				end
			end
			MD_FIX: begin
				if (is_div_q) begin
					if (neg_q) begin
						lo_q <= 32'd0 - lo_q;
					end
					if (rneg_q) begin
						hi_q <= 32'd0 - hi_q;
					end
				end else if (neg_q) begin
					hi_q <= prod_neg[63:32];
					lo_q <= prod_neg[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;

endmodule

// ----- rtl/mips32_integer_execute_core.sv -----
// channel   | handshake                 | carries
// ----------+---------------------------+----------------------------------------
// instr     | instr_valid / instr_stall | instruction_word
// result    | result_valid/result_stall | executed_pc .. unsupported, one word
// cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// an instruction goes through register file read, operand capture, decode, commit;
// mult/div add a pass through the shared shift-add / restoring unit (div by zero skips it)
// a new word is taken only when the previous one has committed; a finished word waits in
// the output register, and commit holds while that register is full and stalled
// reset loads pc and r28/r29/r31 from the default config; no clearing pass is needed
module mips32_integer_execute_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            instr_valid,
	output logic                            instr_stall,
	input  logic [31:0]                     instruction_word,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [31:0]                     executed_pc,
	output logic [31:0]                     following_pc,
	output logic                            write_enable,
	output logic [4:0]                      write_register,
	output logic [31:0]                     write_value,
	output logic                            syscall_request,
	output logic [31:0]                     syscall_code,
	output logic                            unsupported,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mie_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);
	import mie_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_EXEC = 5'b00100,
		ST_MD   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	logic [31:0]     ir_q;
	logic [31:0]     a_q;
	logic [31:0]     b_q;
	logic [31:0]     pc_q;
	logic [31:0]     hi_q;
	logic [31:0]     lo_q;
	logic            pend_q;
	logic [31:0]     pend_tgt_q;
	logic [31:0]     cfg_start_q;
	logic [31:0]     cfg_sp_q;
	logic [31:0]     cfg_gp_q;
	logic [NREG-1:0] valid_q;

	logic            res_valid_q;
	logic [31:0]     res_epc_q;
	logic [31:0]     res_npc_q;
	logic            res_wen_q;
	logic [4:0]      res_wreg_q;
	logic [31:0]     res_wval_q;
	logic            res_sys_q;
	logic [31:0]     res_code_q;
	logic            res_unsup_q;

	logic [31:0]       word;
	logic [RIDX_W-1:0] ra;
	logic [RIDX_W-1:0] rb;
	logic [31:0]       rdata_a;
	logic [31:0]       rdata_b;
	logic [31:0]       a_val;
	logic [31:0]       b_val;
	logic              cfg_we;
	logic              cfg_reg_we;
	logic [RIDX_W-1:0] cfg_reg;
	logic              slot_free;
	logic              commit;
	logic              ram_we;
	logic [RIDX_W-1:0] ram_waddr;
	logic [31:0]       ram_wdata;
	logic [31:0]       following;
	alu_res_t          res;
	md_req_t           md_req;
	logic              md_done;
	logic [31:0]       md_hi;
	logic [31:0]       md_lo;

	function automatic logic [31:0] rst_val(input logic [RIDX_W-1:0] idx,
		input logic [31:0] st, input logic [31:0] sp, input logic [31:0] gp);
		logic [31:0] v;
		v = '0;
		case (idx)
			REG_RA:  v = st;
			REG_SP:  v = sp;
			REG_GP:  v = gp;
			default: v = '0;
		endcase
		return v;
	endfunction

	// syscall reads v0 through the rs port
	assign word = (state_q == ST_IDLE) ? instruction_word : ir_q;
	assign ra   = (word[31:26] == OP_RTYPE && word[5:0] == FN_SYSCALL) ? REG_V0 : word[25:21];
	assign rb   = word[20:16];

	assign a_val = valid_q[ra] ? rdata_a : rst_val(ra, cfg_start_q, cfg_sp_q, cfg_gp_q);
	assign b_val = valid_q[rb] ? rdata_b : rst_val(rb, cfg_start_q, cfg_sp_q, cfg_gp_q);

	assign instr_stall = (state_q != ST_IDLE);
	// a register write never lands on the edge that takes a word
	assign cfg_ready   = (state_q == ST_IDLE) && !instr_valid;
	assign cfg_we      = cfg_valid && cfg_ready;

	always_comb begin
		cfg_reg_we = cfg_we;
		cfg_reg    = REG_ZERO;
		case (cfg_index)
			CFG_START: cfg_reg = REG_RA;
			CFG_SP:    cfg_reg = REG_SP;
			CFG_GP:    cfg_reg = REG_GP;
			default:   cfg_reg_we = 1'b0;
		endcase
	end

	assign slot_free = !res_valid_q || !result_stall;
	assign commit    = (state_q == ST_FIN) && slot_free;

	assign ram_we    = cfg_reg_we || (commit && res.wen);
	assign ram_waddr = cfg_reg_we ? cfg_reg : res.wreg;
	assign ram_wdata = cfg_reg_we ? cfg_data : res.wval;

	assign following = res.taken ? (pc_q + 32'd4) : (pend_q ? pend_tgt_q : (pc_q + 32'd4));

	assign md_req.start  = (state_q == ST_EXEC) && res.md_go;
	assign md_req.is_div = res.md_div;
	assign md_req.sgn    = res.md_sgn;

	mie_ram #(.WIDTH(XLEN), .DEPTH(NREG)) u_regs (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ra),
		.raddr_b (rb),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	mie_alu u_alu (
		.ir  (ir_q),
		.a   (a_q),
		.b   (b_q),
		.pc  (pc_q),
		.hi  (hi_q),
		.lo  (lo_q),
		.res (res)
	);

	mie_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (a_q),
		.b      (b_q),
		.done   (md_done),
		.hi     (md_hi),
		.lo     (md_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= START_RST;
			hi_q        <= '0;
			lo_q        <= '0;
			pend_q      <= 1'b0;
			pend_tgt_q  <= '0;
			cfg_start_q <= START_RST;
			cfg_sp_q    <= SP_RST;
			cfg_gp_q    <= GP_RST;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_START: begin
						cfg_start_q <= cfg_data;
						pc_q        <= cfg_data;
					end
					CFG_SP:  cfg_sp_q <= cfg_data;
					CFG_GP:  cfg_gp_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (instr_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EXEC;
				ST_EXEC: state_q <= res.md_go ? ST_MD : ST_FIN;
				ST_MD: begin
					if (md_done) begin
						hi_q    <= md_hi;
						lo_q    <= md_lo;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (commit) begin
						if (res.hi_we) begin
							hi_q <= a_q;
						end
						if (res.lo_we) begin
							lo_q <= a_q;
						end
						if (res.taken) begin
							pend_tgt_q <= res.target;
						end
						pend_q      <= res.taken;
						pc_q        <= following;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && instr_valid) begin
			ir_q <= instruction_word;
		end
		if (state_q == ST_READ) begin
			a_q <= a_val;
			b_q <= b_val;
		end
		if (commit) begin
			res_epc_q   <= pc_q;
			res_npc_q   <= following;
			res_wen_q   <= res.wen;
			res_wreg_q  <= res.wen ? res.wreg : REG_ZERO;
			res_wval_q  <= res.wval;
			res_sys_q   <= res.sys;
			res_code_q  <= res.sys ? a_q : 32'd0;
			res_unsup_q <= res.unsup;
		end
	end

	assign result_valid    = res_valid_q;
	assign executed_pc     = res_epc_q;
	assign following_pc    = res_npc_q;
	assign write_enable    = res_wen_q;
	assign write_register  = res_wreg_q;
	assign write_value     = res_wval_q;
	assign syscall_request = res_sys_q;
	assign syscall_code    = res_code_q;
	assign unsupported     = res_unsup_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_md_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == ST_MD)
		else $error("mult/div finished while sequencer not waiting");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr != REG_ZERO)
		else $error("register file write to r0");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result_valid && state_q == ST_IDLE)
		else $error("committed word not presented");

endmodule
